### rtl/rgbb_pkg.sv
// Shared types and constants for the RGB 3x3 box blur.
// No dependencies. Used by the interfaces, rgbb_window and rgb_box_blur_3x3.
package rgbb_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // Frame geometry
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_DIM       = 3;
  localparam int ROW_W         = 12;

  // Arithmetic: sum of nine 8-bit values fits 12 bits (max 2295).
  // floor(s / 9) == (s * 7282) >> 16 for every s in that range.
  localparam int CSUM_W     = 12;
  localparam int MUL_W      = 13;
  localparam int PROD_W     = CSUM_W + MUL_W;
  localparam int DIV9_SHIFT = 16;
  localparam logic [MUL_W-1:0] DIV9_MUL = 13'd7282;

  // Result queue depth
  localparam int OUT_DEPTH = 4;

  typedef logic [7:0]        chan_t;
  typedef logic [CSUM_W-1:0] csum_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // Line store entry: row two above and row one above
  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  // Accepted pixel handed to the window stage
  typedef struct packed {
    logic   valid;
    logic   res;
    logic   done;
    pixel_t pix;
  } win_ctrl_t;

  // Registered channel sums for one result
  typedef struct packed {
    logic  valid;
    logic  done;
    csum_t red;
    csum_t green;
    csum_t blue;
  } sums_t;

  // One queued result
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  done;
  } out_item_t;

endpackage

### rtl/rgbb_if.sv
// Valid/ready stream interfaces for pixels in and averaged pixels out.
// Depends on rgbb_pkg.
interface rgbb_in_if import rgbb_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface rgbb_out_if import rgbb_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_avg;
  chan_t green_avg;
  chan_t blue_avg;
  logic  frame_done;

  modport source (output valid, output red_avg, output green_avg, output blue_avg,
                  output frame_done, input ready);
  modport sink (input valid, input red_avg, input green_avg, input blue_avg,
                input frame_done, output ready);
endinterface

### rtl/rgbb_window.sv
// Line store memory, 3x3 window columns and channel sums.
// Depends on rgbb_pkg.
module rgbb_window import rgbb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  win_ctrl_t     ctrl,
  input  logic [CW-1:0] addr,
  output sums_t         sums,
  output logic          busy
);

  // Both line stores share one entry per column
  line_pair_t mem [MAX_WIDTH];
  line_pair_t rd_data;

  // Stage 1: pixel waiting for its line store read
  logic          s1_valid;
  logic          s1_res;
  logic          s1_done;
  pixel_t        s1_pix;
  logic [CW-1:0] s1_addr;

  // Two columns left of the incoming pixel: 0..2 nearest, 3..5 next
  pixel_t win [6];

  pixel_t taps [9];
  csum_t  sum_r, sum_g, sum_b;

  // Read at accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      rd_data <= mem[addr];
    end
    if (s1_valid) begin
      mem[s1_addr] <= '{upper: rd_data.middle, middle: s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      s1_res  <= ctrl.res;
      s1_done <= ctrl.done;
      s1_pix  <= ctrl.pix;
      s1_addr <= addr;
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= rd_data.upper;
      win[1] <= rd_data.middle;
      win[2] <= s1_pix;
    end
  end

  // Sum the nine neighbours per channel
  always_comb begin
    taps[0] = rd_data.upper;
    taps[1] = rd_data.middle;
    taps[2] = s1_pix;
    for (int i = 0; i < 6; i++) begin
      taps[3 + i] = win[i];
    end
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 9; i++) begin
      sum_r = sum_r + CSUM_W'(taps[i].red);
      sum_g = sum_g + CSUM_W'(taps[i].green);
      sum_b = sum_b + CSUM_W'(taps[i].blue);
    end
  end

  // Sum register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sums.valid <= 1'b0;
    end else begin
      sums.valid <= s1_valid && s1_res;
    end
    sums.done  <= s1_done;
    sums.red   <= sum_r;
    sums.green <= sum_g;
    sums.blue  <= sum_b;
  end

  assign busy = s1_valid && s1_res;

`ifndef ASSERT_OFF
  // Back-to-back pixels never touch the same column in one cycle
  assert property (@(posedge clk) disable iff (rst)
    ctrl.valid && s1_valid |-> addr != s1_addr)
    else $error("line store read and write collide");

  // A sum appears only in the cycle after a result pixel in stage 1
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_res |=> sums.valid)
    else $error("result lost between stage 1 and sums");
`endif

endmodule

### rtl/rgb_box_blur_3x3.sv
// Top level of the RGB 3x3 box blur: counters, divide by nine, result queue.
// Depends on rgbb_pkg, rgbb_if and rgbb_window.

// Takes one RGB pixel per clock in raster order while input ready is high and,
// for every interior pixel, gives floor(3x3 sum / 9) per channel; border rows
// and columns give nothing. The last interior result of a frame has frame_done
// set and the position counters then start the next frame. Sustained rate is
// one pixel per clock while the output takes results: each pixel costs one
// read and one write of the line store memory, on separate ports and always
// at different columns. A result becomes valid at the output after its pixel
// passes the line store read at the accepting edge, then the sum register,
// then the divide into the four-entry result queue. Input ready drops only
// when the queue plus the results still in flight would fill it. The line
// stores come up undefined after reset and need one full row (two for the upper
// row) before results are meaningful; there is no clearing pass. frame_width and
// frame_height are clamped to 3..MAX_WIDTH and 3..4096, and should be
// written only while no pixel is in flight.
module rgb_box_blur_3x3 import rgbb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  rgbb_in_if.sink               pix_in,
  rgbb_out_if.source            avg_out
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMPW  = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int PW    = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int OCC_W = $clog2(OUT_DEPTH + 3);

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;

  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;

  logic [CMPW-1:0]       fw_ext, w_lim, w_m1;
  logic [CFG_DATA_W-1:0] h_lim, h_m1;
  logic                  row_end, last_row, res0, accept;

  win_ctrl_t ctrl;
  sums_t     sums;
  logic      win_busy;

  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  out_item_t         item_next;

  out_item_t        fifo [OUT_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0] out_cnt;
  logic [OCC_W-1:0] occ;
  logic             pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_wr_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_wr_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Clamped geometry
  always_comb begin
    fw_ext = CMPW'(frame_width);
    if (fw_ext < CMPW'(MIN_DIM)) begin
      w_lim = CMPW'(MIN_DIM);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_lim = CMPW'(MAX_WIDTH);
    end else begin
      w_lim = fw_ext;
    end
    w_m1 = w_lim - CMPW'(1);

    if (frame_height < CFG_DATA_W'(MIN_DIM)) begin
      h_lim = CFG_DATA_W'(MIN_DIM);
    end else if (frame_height > CFG_DATA_W'(MAX_HEIGHT)) begin
      h_lim = CFG_DATA_W'(MAX_HEIGHT);
    end else begin
      h_lim = frame_height;
    end
    h_m1 = h_lim - CFG_DATA_W'(1);
  end

  assign row_end  = CMPW'(col_count) >= w_m1;
  assign last_row = CFG_DATA_W'(row_count) >= h_m1;
  assign res0     = (row_count >= ROW_W'(2)) && (col_count >= CW'(2));
  assign accept   = pix_in.valid && pix_in.ready;

  // Position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  always_comb begin
    ctrl.valid     = accept;
    ctrl.res       = res0;
    ctrl.done      = row_end && last_row;
    ctrl.pix.red   = pix_in.red_in;
    ctrl.pix.green = pix_in.green_in;
    ctrl.pix.blue  = pix_in.blue_in;
  end

  rgbb_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .addr (col_count),
    .sums (sums),
    .busy (win_busy)
  );

  // Divide by nine through the reciprocal
  always_comb begin
    prod_r = PROD_W'(sums.red) * PROD_W'(DIV9_MUL);
    prod_g = PROD_W'(sums.green) * PROD_W'(DIV9_MUL);
    prod_b = PROD_W'(sums.blue) * PROD_W'(DIV9_MUL);
    item_next.red   = prod_r[DIV9_SHIFT +: 8];
    item_next.green = prod_g[DIV9_SHIFT +: 8];
    item_next.blue  = prod_b[DIV9_SHIFT +: 8];
    item_next.done  = sums.done;
  end

  // Result queue with room reserved for items in flight
  assign pop = avg_out.valid && avg_out.ready;
  assign occ = OCC_W'(out_cnt) + OCC_W'(win_busy) + OCC_W'(sums.valid);
  assign pix_in.ready = occ < OCC_W'(OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (sums.valid) begin
      fifo[wr_ptr] <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      out_cnt <= '0;
    end else begin
      if (sums.valid) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      out_cnt <= out_cnt + CNT_W'(sums.valid) - CNT_W'(pop);
    end
  end

  assign avg_out.valid      = out_cnt != '0;
  assign avg_out.red_avg    = fifo[rd_ptr].red;
  assign avg_out.green_avg  = fifo[rd_ptr].green;
  assign avg_out.blue_avg   = fifo[rd_ptr].blue;
  assign avg_out.frame_done = fifo[rd_ptr].done;

`ifndef ASSERT_OFF
  // Queue plus results in flight never exceed the queue depth
  assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(OUT_DEPTH))
    else $error("result queue overcommitted");

  // A push into a full queue must coincide with a pop
  assert property (@(posedge clk) disable iff (rst)
    sums.valid && out_cnt == CNT_W'(OUT_DEPTH) |-> pop)
    else $error("result queue overflow");
`endif

endmodule
